[src/fsa_pkg.sv]
// Shared types, constants and arithmetic helpers of the film sample accumulator.
`default_nettype none
package fsa_pkg;

    // Frame store geometry.
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int ADDR_W     = COL_W + ROW_W;
    localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
    localparam int DIM_W      = 9;

    // Request codes.
    localparam logic [1:0] REQ_ACCUM = 2'd0;
    localparam logic [1:0] REQ_CLEAR = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;
    localparam logic [1:0] REQ_TAKE  = 2'd3;

    // Configuration register indexes.
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    localparam logic signed [33:0] SUM_MAX = 34'sd2147483647;
    localparam logic signed [33:0] SUM_MIN = -34'sd2147483648;

    // One classified request word as it sits in the queue.
    typedef struct packed {
        logic [1:0]          req;
        logic                hit;
        logic [7:0]          col;
        logic [7:0]          row;
        logic [ADDR_W-1:0]   addr;
        logic signed [15:0]  w;
        logic [15:0]         a;
        logic [15:0]         rx;
        logic [15:0]         ry;
        logic [15:0]         rz;
    } t_item;

    // Queue head as seen by the back end.
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_q_head;

    // Back end control toward the front end.
    typedef struct packed {
        logic pop;
        logic clearing;
    } t_q_ctl;

    // The five sums of one pixel.
    typedef struct packed {
        logic signed [31:0] w;
        logic signed [31:0] a;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_sums;

    // Saturating add of a contribution to a 32-bit sum.
    function automatic logic signed [31:0] sat_add(input logic signed [31:0] acc,
                                                   input logic signed [25:0] d);
        logic signed [33:0] s;
        s = 34'(acc) + 34'(d);
        if (s > SUM_MAX) begin
            sat_add = 32'(SUM_MAX);
        end else if (s < SUM_MIN) begin
            sat_add = 32'(SUM_MIN);
        end else begin
            sat_add = s[31:0];
        end
    endfunction

endpackage
`default_nettype wire

[src/fsa_ram.sv]
// Generic single write port RAM with a registered read port.
`default_nettype none
module fsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

[src/fsa_div.sv]
// Restoring divider, one quotient bit a cycle, for the luminance ratio.
`default_nettype none
module fsa_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [38:0] i_dividend,
    input  wire logic [30:0] i_divisor,
    output logic             o_done,
    output logic [38:0]      o_quotient
);

    logic        r_busy, n_busy;
    logic [5:0]  r_cnt, n_cnt;
    logic [31:0] r_rem, n_rem;
    logic [38:0] r_quo, n_quo;
    logic [30:0] r_div, n_div;
    logic        r_done, n_done;
    logic [31:0] trial;
    logic        qbit;

    // One shift and trial subtract per cycle.
    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_div  = r_div;
        n_done = 1'b0;
        trial  = {r_rem[30:0], r_quo[38]};
        qbit   = (trial >= {1'b0, r_div});
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = 6'd0;
            n_rem  = 32'd0;
            n_quo  = i_dividend;
            n_div  = i_divisor;
        end else if (r_busy) begin
            n_rem = qbit ? (trial - {1'b0, r_div}) : trial;
            n_quo = {r_quo[37:0], qbit};
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd38) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_div <= n_div;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule
`default_nettype wire

[src/fsa_front.sv]
// Front end: accepts request words, maps sample positions to pixels, queues them.
`default_nettype none
module fsa_front (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic [fsa_pkg::DIM_W-1:0]  i_frame_width,
    input  wire logic [fsa_pkg::DIM_W-1:0]  i_frame_height,
    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire logic [1:0]                 i_req_type,
    input  wire logic signed [17:0]         i_pos_x,
    input  wire logic signed [17:0]         i_pos_y,
    input  wire logic signed [15:0]         i_sample_weight,
    input  wire logic [15:0]                i_sample_alpha,
    input  wire logic [15:0]                i_rad_x,
    input  wire logic [15:0]                i_rad_y,
    input  wire logic [15:0]                i_rad_z,
    input  wire logic [7:0]                 i_pixel_col,
    input  wire logic [7:0]                 i_pixel_row,
    input  wire fsa_pkg::t_q_ctl            i_ctl,
    output fsa_pkg::t_q_head                o_head
);

    logic [fsa_pkg::DIM_W-1:0] eff_w, eff_h;
    logic [25:0]               prod_x, prod_y;
    logic [9:0]                col, row;
    logic                      hit;
    fsa_pkg::t_item            item;
    fsa_pkg::t_item            r_q [2];
    logic                      r_wptr, r_rptr;
    logic [1:0]                r_count;
    logic                      push, pop;

    // Clamp the resolution and map the position to a pixel.
    always_comb begin
        eff_w = (i_frame_width > fsa_pkg::DIM_W'(fsa_pkg::MAX_WIDTH)) ?
                fsa_pkg::DIM_W'(fsa_pkg::MAX_WIDTH) : i_frame_width;
        eff_h = (i_frame_height > fsa_pkg::DIM_W'(fsa_pkg::MAX_HEIGHT)) ?
                fsa_pkg::DIM_W'(fsa_pkg::MAX_HEIGHT) : i_frame_height;
        prod_x = 26'(i_pos_x[16:0]) * 26'(eff_w);
        prod_y = 26'(i_pos_y[16:0]) * 26'(eff_h);
        col    = prod_x[25:16];
        row    = prod_y[25:16];
        hit    = !i_pos_x[17] && !i_pos_y[17] &&
                 (col < 10'(eff_w)) && (row < 10'(eff_h));
    end

    // Build the queued word.
    always_comb begin
        item     = '0;
        item.req = i_req_type;
        item.hit = hit && (i_req_type == fsa_pkg::REQ_ACCUM);
        item.col = col[7:0];
        item.row = row[7:0];
        item.w   = i_sample_weight;
        item.a   = i_sample_alpha;
        item.rx  = i_rad_x;
        item.ry  = i_rad_y;
        item.rz  = i_rad_z;
        if (i_req_type == fsa_pkg::REQ_READ) begin
            item.addr = {fsa_pkg::ROW_W'(i_pixel_row), fsa_pkg::COL_W'(i_pixel_col)};
        end else begin
            item.addr = {row[fsa_pkg::ROW_W-1:0], col[fsa_pkg::COL_W-1:0]};
        end
    end

    assign o_stall = (r_count == 2'd2) || i_ctl.clearing;
    assign push    = i_valid && !o_stall;
    assign pop     = i_ctl.pop && (r_count != 2'd0);

    // Two word queue between the front and the back end.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) begin
                r_wptr <= !r_wptr;
            end
            if (pop) begin
                r_rptr <= !r_rptr;
            end
            r_count <= r_count + 2'(push) - 2'(pop);
        end
        if (push) begin
            r_q[r_wptr] <= item;
        end
    end

    assign o_head.valid = (r_count != 2'd0);
    assign o_head.item  = r_q[r_rptr];

endmodule
`default_nettype wire

[src/fsa_back.sv]
// Back end: clears and updates the frame store, tracks box and peak, drives results.
`default_nettype none
module fsa_back (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire fsa_pkg::t_q_head    i_head,
    output fsa_pkg::t_q_ctl          o_ctl,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output logic                     o_hit,
    output logic                     o_box_valid,
    output logic [7:0]               o_box_min_col,
    output logic [7:0]               o_box_min_row,
    output logic [7:0]               o_box_max_col,
    output logic [7:0]               o_box_max_row,
    output logic [31:0]              o_peak_luminance,
    output logic signed [31:0]       o_acc_weight,
    output logic signed [31:0]       o_acc_alpha,
    output logic signed [31:0]       o_acc_x,
    output logic signed [31:0]       o_acc_y,
    output logic signed [31:0]       o_acc_z
);

    localparam logic [2:0] S_SWEEP = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_MUL2  = 3'd4;
    localparam logic [2:0] S_ADD   = 3'd5;
    localparam logic [2:0] S_DIV   = 3'd6;
    localparam logic [2:0] S_EMIT  = 3'd7;

    logic [2:0]                  r_state;
    logic [fsa_pkg::ADDR_W-1:0]  r_cnt;
    fsa_pkg::t_item              r_item;
    fsa_pkg::t_sums              r_old, r_acc, new_sums, rdata;
    logic signed [32:0]          r_wa;
    logic signed [25:0]          r_cx, r_cy, r_cz;
    logic signed [49:0]          px, py, pz;
    logic                        r_bv;
    logic [7:0]                  r_bmin_c, r_bmin_r, r_bmax_c, r_bmax_r;
    logic [31:0]                 r_peak;
    logic                        out_free;
    logic                        we;
    logic [fsa_pkg::ADDR_W-1:0]  waddr;
    fsa_pkg::t_sums              wdata;
    logic                        div_start, div_done;
    logic [38:0]                 quo;
    logic [31:0]                 lum;

    assign out_free  = !o_valid || !i_stall;
    assign o_ctl.pop = (r_state == S_IDLE) && i_head.valid;
    assign o_ctl.clearing = (r_state == S_SWEEP);

    // Contributions of the sample, one register after each product.
    assign px = 50'(signed'({1'b0, r_item.rx})) * 50'(r_wa);
    assign py = 50'(signed'({1'b0, r_item.ry})) * 50'(r_wa);
    assign pz = 50'(signed'({1'b0, r_item.rz})) * 50'(r_wa);

    // Saturated new sums of the hit pixel.
    always_comb begin
        new_sums.w = fsa_pkg::sat_add(r_old.w, 26'(r_item.w));
        new_sums.a = fsa_pkg::sat_add(r_old.a, 26'(signed'(r_wa[32:16])));
        new_sums.x = fsa_pkg::sat_add(r_old.x, r_cx);
        new_sums.y = fsa_pkg::sat_add(r_old.y, r_cy);
        new_sums.z = fsa_pkg::sat_add(r_old.z, r_cz);
    end

    // Store write port: clearing sweep or pixel update.
    always_comb begin
        we    = 1'b0;
        waddr = r_item.addr;
        wdata = new_sums;
        if (r_state == S_SWEEP) begin
            we    = 1'b1;
            waddr = r_cnt;
            wdata = '0;
        end else if (r_state == S_ADD) begin
            we = 1'b1;
        end
    end

    fsa_ram #(
        .WIDTH($bits(fsa_pkg::t_sums)),
        .DEPTH(fsa_pkg::DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(r_item.addr),
        .o_rdata(rdata)
    );

    assign div_start = (r_state == S_ADD) && (new_sums.w > 0) && (new_sums.y > 0);

    fsa_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_dividend({new_sums.y[30:0], 8'd0}),
        .i_divisor (new_sums.w[30:0]),
        .o_done    (div_done),
        .o_quotient(quo)
    );

    assign lum = (|quo[38:32]) ? 32'hFFFF_FFFF : quo[31:0];

    // Request sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_SWEEP;
            r_cnt    <= '0;
            r_item   <= '0;
            o_valid  <= 1'b0;
            r_bv     <= 1'b0;
            r_bmin_c <= 8'd0;
            r_bmin_r <= 8'd0;
            r_bmax_c <= 8'd0;
            r_bmax_r <= 8'd0;
            r_peak   <= 32'd0;
        end else begin
            if (o_valid && !i_stall && (r_state != S_EMIT)) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                S_SWEEP: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (&r_cnt) begin
                        r_state <= (r_item.req == fsa_pkg::REQ_CLEAR) ? S_EMIT : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_head.valid) begin
                        r_item <= i_head.item;
                        r_acc  <= '0;
                        case (i_head.item.req)
                            fsa_pkg::REQ_CLEAR: begin
                                r_bv     <= 1'b0;
                                r_bmin_c <= 8'd0;
                                r_bmin_r <= 8'd0;
                                r_bmax_c <= 8'd0;
                                r_bmax_r <= 8'd0;
                                r_peak   <= 32'd0;
                                r_cnt    <= '0;
                                r_state  <= S_SWEEP;
                            end
                            fsa_pkg::REQ_READ: r_state <= S_READ;
                            fsa_pkg::REQ_ACCUM:
                                r_state <= i_head.item.hit ? S_READ : S_EMIT;
                            default: r_state <= S_EMIT;
                        endcase
                    end
                end
                S_READ: begin
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_old <= rdata;
                    r_wa  <= 33'(r_item.w) * 33'(signed'({1'b0, r_item.a}));
                    if (r_item.req == fsa_pkg::REQ_READ) begin
                        r_acc   <= rdata;
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_MUL2;
                    end
                end
                S_MUL2: begin
                    r_cx    <= px[49:24];
                    r_cy    <= py[49:24];
                    r_cz    <= pz[49:24];
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_acc <= new_sums;
                    if (!r_bv) begin
                        r_bv     <= 1'b1;
                        r_bmin_c <= r_item.col;
                        r_bmax_c <= r_item.col;
                        r_bmin_r <= r_item.row;
                        r_bmax_r <= r_item.row;
                    end else begin
                        if (r_item.col < r_bmin_c) r_bmin_c <= r_item.col;
                        if (r_item.col > r_bmax_c) r_bmax_c <= r_item.col;
                        if (r_item.row < r_bmin_r) r_bmin_r <= r_item.row;
                        if (r_item.row > r_bmax_r) r_bmax_r <= r_item.row;
                    end
                    r_state <= div_start ? S_DIV : S_EMIT;
                end
                S_DIV: begin
                    if (div_done) begin
                        if (lum > r_peak) begin
                            r_peak <= lum;
                        end
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        o_valid <= 1'b1;
                        r_state <= S_IDLE;
                        if (r_item.req == fsa_pkg::REQ_TAKE) begin
                            r_bv     <= 1'b0;
                            r_bmin_c <= 8'd0;
                            r_bmin_r <= 8'd0;
                            r_bmax_c <= 8'd0;
                            r_bmax_r <= 8'd0;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Result word register.
    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT && out_free) begin
            o_hit            <= r_item.hit;
            o_box_valid      <= r_bv;
            o_box_min_col    <= r_bmin_c;
            o_box_min_row    <= r_bmin_r;
            o_box_max_col    <= r_bmax_c;
            o_box_max_row    <= r_bmax_r;
            o_peak_luminance <= r_peak;
            o_acc_weight     <= r_acc.w;
            o_acc_alpha      <= r_acc.a;
            o_acc_x          <= r_acc.x;
            o_acc_y          <= r_acc.y;
            o_acc_z          <= r_acc.z;
        end
    end

endmodule
`default_nettype wire

[src/film_sample_accumulator_core.sv]
// Top level of the film sample accumulator: config registers, front end, back end.
// State path: take-box or missed sample idle, emit; read idle, read, mul, emit;
// accumulate hit idle, read, mul, mul2, add, div if the luminance divider runs, emit.
// Throughput: one request word at a time in the back end, set by the store
// read-modify-write and the divider; a two word queue lets the front keep accepting.
// Reset and each clear sweep the 65536 entry store, one entry a cycle, without input.
`default_nettype none
module film_sample_accumulator_core (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic                  i_cfg_index,
    input  wire logic [8:0]            i_cfg_data,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [1:0]            i_req_type,
    input  wire logic signed [17:0]    i_pos_x,
    input  wire logic signed [17:0]    i_pos_y,
    input  wire logic signed [15:0]    i_sample_weight,
    input  wire logic [15:0]           i_sample_alpha,
    input  wire logic [15:0]           i_rad_x,
    input  wire logic [15:0]           i_rad_y,
    input  wire logic [15:0]           i_rad_z,
    input  wire logic [7:0]            i_pixel_col,
    input  wire logic [7:0]            i_pixel_row,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic                       o_hit,
    output logic                       o_box_valid,
    output logic [7:0]                 o_box_min_col,
    output logic [7:0]                 o_box_min_row,
    output logic [7:0]                 o_box_max_col,
    output logic [7:0]                 o_box_max_row,
    output logic [31:0]                o_peak_luminance,
    output logic signed [31:0]         o_acc_weight,
    output logic signed [31:0]         o_acc_alpha,
    output logic signed [31:0]         o_acc_x,
    output logic signed [31:0]         o_acc_y,
    output logic signed [31:0]         o_acc_z
);

    logic [fsa_pkg::DIM_W-1:0] r_frame_width, r_frame_height;
    fsa_pkg::t_q_head          head;
    fsa_pkg::t_q_ctl           ctl;

    assign o_cfg_ready = 1'b1;

    // Resolution registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= fsa_pkg::DIM_W'(256);
            r_frame_height <= fsa_pkg::DIM_W'(256);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                fsa_pkg::CFG_WIDTH:  r_frame_width  <= i_cfg_data;
                fsa_pkg::CFG_HEIGHT: r_frame_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    fsa_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_req_type     (i_req_type),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_sample_weight(i_sample_weight),
        .i_sample_alpha (i_sample_alpha),
        .i_rad_x        (i_rad_x),
        .i_rad_y        (i_rad_y),
        .i_rad_z        (i_rad_z),
        .i_pixel_col    (i_pixel_col),
        .i_pixel_row    (i_pixel_row),
        .i_ctl          (ctl),
        .o_head         (head)
    );

    fsa_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (head),
        .o_ctl           (ctl),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_hit           (o_hit),
        .o_box_valid     (o_box_valid),
        .o_box_min_col   (o_box_min_col),
        .o_box_min_row   (o_box_min_row),
        .o_box_max_col   (o_box_max_col),
        .o_box_max_row   (o_box_max_row),
        .o_peak_luminance(o_peak_luminance),
        .o_acc_weight    (o_acc_weight),
        .o_acc_alpha     (o_acc_alpha),
        .o_acc_x         (o_acc_x),
        .o_acc_y         (o_acc_y),
        .o_acc_z         (o_acc_z)
    );

    // No request word enters while the store is being swept.
    a_no_accept_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.clearing |-> o_stall)
        else $error("request word accepted during store sweep");

    // A hit always leaves a non-empty dirty box.
    a_hit_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_hit) |-> o_box_valid)
        else $error("hit reported with an empty dirty box");

    // A valid dirty box is well ordered.
    a_box_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_box_valid) |->
            (o_box_min_col <= o_box_max_col) && (o_box_min_row <= o_box_max_row))
        else $error("dirty box minimum exceeds maximum");

endmodule
`default_nettype wire
